>>> src/mmmr_pkg.sv
package mmmr_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int SRC_W       = 2;
    localparam int MASK_W      = 4;
    localparam int MAX_BEATS   = 3;

    localparam logic [7:0] STATUS_BIT   = 8'h80;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] MTC_QFRAME   = 8'hF1;
    localparam logic [7:0] SONG_POS     = 8'hF2;
    localparam logic [7:0] SONG_SELECT  = 8'hF3;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] MIDI_CLOCK   = 8'hF8;
    localparam logic [3:0] HI_SYSTEM    = 4'hF;
    localparam logic [3:0] HI_PROG_CHG  = 4'hC;
    localparam logic [3:0] HI_CHAN_PRES = 4'hD;

    typedef struct packed {
        logic [7:0] run_status;
        logic       common_flag;
        logic [1:0] param_count;
        logic [1:0] param_pos;
        logic [6:0] first_param;
        logic       sysex_flag;
    } src_state_t;

    localparam int STATE_W = $bits(src_state_t);

    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [1:0]                last_pos;
        logic                      byte_valid;
        logic                      sysex;
    } beat_group_t;

endpackage

>>> src/mmmr_ram.sv
module mmmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/mmmr_step.sv
module mmmr_step (
    input  logic [7:0]              data_byte,
    input  mmmr_pkg::src_state_t    cur_state,
    input  logic                    drop_clock,
    input  logic [7:0]              merged_rs,
    output mmmr_pkg::src_state_t    new_state,
    output logic [7:0]              new_merged_rs,
    output mmmr_pkg::beat_group_t   group
);

    always_comb
    begin
        logic [mmmr_pkg::MAX_BEATS-1:0][7:0] b;
        logic [1:0] n;
        logic [1:0] idx;
        logic       sx;
        mmmr_pkg::src_state_t st;
        logic [7:0] mrs;

        b   = '0;
        n   = 2'd0;
        st  = cur_state;
        mrs = merged_rs;
        sx  = cur_state.sysex_flag;
        idx = 2'd0;

        if (data_byte >= mmmr_pkg::MIDI_CLOCK)
        begin
            if (!(data_byte == mmmr_pkg::MIDI_CLOCK && drop_clock))
            begin
                b[0] = data_byte;
                n    = 2'd1;
            end
        end
        else if ((data_byte & mmmr_pkg::STATUS_BIT) != 8'd0)
        begin
            st.param_pos   = 2'd0;
            st.common_flag = 1'b0;
            st.sysex_flag  = 1'b0;
            if (data_byte[7:4] == mmmr_pkg::HI_SYSTEM)
            begin
                if (data_byte == mmmr_pkg::MTC_QFRAME || data_byte == mmmr_pkg::SONG_SELECT
                    || data_byte == mmmr_pkg::SONG_POS)
                begin
                    st.run_status  = data_byte;
                    st.common_flag = 1'b1;
                    st.param_count = (data_byte == mmmr_pkg::SONG_POS) ? 2'd2 : 2'd1;
                end
                else
                begin
                    st.sysex_flag = (data_byte == mmmr_pkg::SYSEX_START);
                    st.run_status = 8'd0;
                    mrs           = 8'd0;
                    b[0]          = data_byte;
                    n             = 2'd1;
                end
            end
            else
            begin
                st.run_status  = data_byte;
                st.param_count = (data_byte[7:4] == mmmr_pkg::HI_PROG_CHG
                                  || data_byte[7:4] == mmmr_pkg::HI_CHAN_PRES) ? 2'd1 : 2'd2;
            end
            sx = st.sysex_flag;
        end
        else if (cur_state.sysex_flag)
        begin
            b[0] = data_byte;
            n    = 2'd1;
            sx   = 1'b1;
        end
        else if (cur_state.run_status != 8'd0)
        begin
            if (cur_state.param_pos == 2'd0)
            begin
                st.first_param = data_byte[6:0];
            end
            idx          = cur_state.param_pos + 2'd1;
            st.param_pos = idx;
            if (idx >= cur_state.param_count)
            begin
                if (cur_state.run_status != merged_rs)
                begin
                    b[n] = cur_state.run_status;
                    n    = n + 2'd1;
                    mrs  = cur_state.run_status;
                end
                if (cur_state.param_count > 2'd0)
                begin
                    b[n] = {1'b0, st.first_param};
                    n    = n + 2'd1;
                end
                if (cur_state.param_count > 2'd1 && n < 2'(mmmr_pkg::MAX_BEATS))
                begin
                    b[n] = data_byte;
                    n    = n + 2'd1;
                end
                st.param_pos = 2'd0;
                if (cur_state.common_flag)
                begin
                    st.common_flag = 1'b0;
                    st.run_status  = 8'd0;
                    mrs            = 8'd0;
                end
            end
        end

        new_state        = st;
        new_merged_rs    = mrs;
        group.bytes      = b;
        group.byte_valid = (n != 2'd0);
        group.last_pos   = (n == 2'd0) ? 2'd0 : n - 2'd1;
        group.sysex      = sx;
    end

endmodule

>>> src/midi_message_merge_reassembler.sv
// Merges tagged MIDI bytes from up to four sources into one stream with running status.
// Each input beat gives one to three output beats: the status byte (only when it differs
// from the output running status), then the parameters; a beat with tuser[0] low is an
// empty result. The per-source state sits in a four-entry RAM read on acceptance and
// written back when the beat is processed, with forwarding when the next beat, taken in
// that same cycle, shares its source. An accepted input beat is registered in a holding
// stage, then processed into the output group register that sends its output beats. The
// single-byte output port sets the rate: an input beat waits in the holding stage while
// the result ahead of it drains, so while the stage is full a new input beat is taken only
// as the held beat moves on, when that result's last beat is accepted; output stalls delay it.
// The clock drop mask is written on the cfg channel.
module midi_message_merge_reassembler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] source_in_sysex
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [mmmr_pkg::MASK_W-1:0]      drop_mask_reg;
    logic [mmmr_pkg::NUM_SOURCES-1:0] ent_valid_reg;
    logic                             s1_valid_reg;
    logic [mmmr_pkg::SRC_W-1:0]       s1_src_reg;
    logic [7:0]                       s1_byte_reg;
    logic                             s1_fwd_reg;
    mmmr_pkg::src_state_t             fwd_data_reg;
    logic [7:0]                       merged_rs_reg;
    mmmr_pkg::beat_group_t            grp_reg;
    logic                             grp_valid_reg;
    logic [1:0]                       pos_reg;

    logic                             in_fire;
    logic                             out_fire;
    logic                             grp_load;
    logic                             s1_proc;
    logic [mmmr_pkg::STATE_W-1:0]     ram_rdata;
    mmmr_pkg::src_state_t             cur_state;
    mmmr_pkg::src_state_t             new_state;
    logic [7:0]                       merged_rs_next;
    mmmr_pkg::beat_group_t            grp_next;

    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign grp_load      = !grp_valid_reg || (m_axis_tready && m_axis_tlast);
    assign s1_proc       = s1_valid_reg && grp_load;
    assign s_axis_tready = !s1_valid_reg || s1_proc;

    assign m_axis_tvalid = grp_valid_reg;
    assign m_axis_tdata  = grp_reg.bytes[pos_reg];
    assign m_axis_tlast  = (pos_reg == grp_reg.last_pos);
    assign m_axis_tuser  = {grp_reg.sysex, grp_reg.byte_valid};

    mmmr_ram #(
        .WIDTH (mmmr_pkg::STATE_W),
        .DEPTH (mmmr_pkg::NUM_SOURCES)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_proc),
        .waddr (s1_src_reg),
        .wdata (new_state),
        .re    (in_fire),
        .raddr (s_axis_tuser),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (ent_valid_reg[s1_src_reg])
        begin
            cur_state = mmmr_pkg::src_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = '0;
        end
    end

    mmmr_step u_step (
        .data_byte     (s1_byte_reg),
        .cur_state     (cur_state),
        .drop_clock    (drop_mask_reg[s1_src_reg]),
        .merged_rs     (merged_rs_reg),
        .new_state     (new_state),
        .new_merged_rs (merged_rs_next),
        .group         (grp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_mask_reg <= 4'd14;
            ent_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            merged_rs_reg <= 8'd0;
            grp_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                drop_mask_reg <= cfg_data;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= s1_proc && (s1_src_reg == s_axis_tuser);
            end
            else if (s1_proc)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_proc)
            begin
                ent_valid_reg[s1_src_reg] <= 1'b1;
                merged_rs_reg             <= merged_rs_next;
                grp_valid_reg             <= 1'b1;
                pos_reg                   <= 2'd0;
            end
            else if (out_fire)
            begin
                if (m_axis_tlast)
                begin
                    grp_valid_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    // payload: hold the beat, the state copy and the output group, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg  <= s_axis_tuser;
            s1_byte_reg <= s_axis_tdata;
        end
        if (s1_proc)
        begin
            fwd_data_reg <= new_state;
            grp_reg      <= grp_next;
        end
    end

endmodule

>>> src/mmmr_checker.sv
module mmmr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // an empty result is alone and carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("empty result not alone or not zero");

    // a realtime byte is always a single-beat result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata >= mmmr_pkg::MIDI_CLOCK)
        |-> m_axis_tlast)
    else $error("realtime byte inside a multi-beat result");

    // beats of one result follow without a gap and keep the sysex flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && $stable(m_axis_tuser[1])))
    else $error("result broken up or sysex flag changed within it");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

endmodule

bind midi_message_merge_reassembler mmmr_checker u_mmmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
